// File: rtl/kbm_pkg.sv
// kbm_pkg: shared types, keyword table and helper functions
// for the keyword blacklist matcher.
// No dependencies.
package kbm_pkg;

	localparam int MAX_KEY_LEN = 20;
	localparam int KEY_COUNT   = 31;
	localparam int HIST_LEN    = MAX_KEY_LEN - 1;
	localparam int KEY_BITS    = MAX_KEY_LEN * 8;

	typedef logic [7:0] char_t;

	typedef struct packed {
		char_t ch;
		logic  valid;
	} kbm_tap_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} kbm_ctrl_t;

	// Right-aligned: the last character of a keyword sits in byte 0.
	localparam logic [KEY_BITS-1:0] KEY_TABLE [KEY_COUNT] = '{
		KEY_BITS'({56'h646973636f7264, " gg"}),
		KEY_BITS'(".gg/"),
		KEY_BITS'(".gg"),
		KEY_BITS'({56'h646973636f7264, ".gg"}),
		KEY_BITS'("pu763a4kp7"),
		KEY_BITS'("dsc.gg"),
		KEY_BITS'("boost your"),
		KEY_BITS'("boost youtube"),
		KEY_BITS'("boost view"),
		KEY_BITS'("boost like"),
		KEY_BITS'("trade"),
		KEY_BITS'("giftcard"),
		KEY_BITS'({"approved by ", 48'h726f62746f70}),
		KEY_BITS'("you want to get free"),
		KEY_BITS'("to get free"),
		KEY_BITS'("join my server"),
		KEY_BITS'("check out my server"),
		KEY_BITS'("join us"),
		KEY_BITS'("free reward"),
		KEY_BITS'("win a prize"),
		KEY_BITS'("limited time"),
		KEY_BITS'("get free"),
		KEY_BITS'("free creator points"),
		KEY_BITS'("official geometry"),
		KEY_BITS'("official gd disc"),
		KEY_BITS'("official gd serv"),
		KEY_BITS'("check my level"),
		KEY_BITS'("check my new level"),
		KEY_BITS'("check out my new l"),
		KEY_BITS'("check out my l"),
		KEY_BITS'("my level")
	};

	// Character expected j positions back from the newest byte.
	function automatic char_t key_char(input int k, input int j);
		return KEY_TABLE[k][8*j +: 8];
	endfunction

	// Position j takes part in keyword k.
	function automatic logic key_care(input int k, input int j);
		return KEY_TABLE[k][8*j +: 8] != 8'h00;
	endfunction

	function automatic logic [KEY_COUNT-1:0] key_nonempty();
		logic [KEY_COUNT-1:0] m;
		for (int k = 0; k < KEY_COUNT; k++) begin
			m[k] = KEY_TABLE[k] != '0;
		end
		return m;
	endfunction

	function automatic char_t fold_char(input char_t b);
		if (b >= 8'h41 && b <= 8'h5a) begin
			return b + 8'h20;
		end
		return b;
	endfunction

endpackage

// File: rtl/kbm_char_cmp.sv
// kbm_char_cmp: compares one window byte against the expected character
// of every keyword at that position. Depends on kbm_pkg.
module kbm_char_cmp import kbm_pkg::*; (
	input  kbm_tap_t                    tap,
	input  logic [KEY_COUNT-1:0][7:0]   exp_chars,
	input  logic [KEY_COUNT-1:0]        care,
	output logic [KEY_COUNT-1:0]        hits
);

	always_comb begin
		for (int k = 0; k < KEY_COUNT; k++) begin
			hits[k] = !care[k] || (tap.valid && tap.ch == exp_chars[k]);
		end
	end

endmodule

// File: rtl/kbm_cell.sv
// kbm_cell: one history cell; holds a folded byte and its valid bit,
// passes it on to the next cell, and matches it per keyword.
// Depends on kbm_pkg and kbm_char_cmp.
module kbm_cell import kbm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kbm_ctrl_t                   ctrl,
	input  kbm_tap_t                    tap_in,
	input  logic [KEY_COUNT-1:0][7:0]   exp_chars,
	input  logic [KEY_COUNT-1:0]        care,
	output kbm_tap_t                    tap_out,
	output logic [KEY_COUNT-1:0]        hits
);

	logic  valid_q;
	char_t ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= tap_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			ch_q <= tap_in.ch;
		end
	end

	assign tap_out.ch    = ch_q;
	assign tap_out.valid = valid_q;

	kbm_char_cmp u_cmp (
		.tap       (tap_out),
		.exp_chars (exp_chars),
		.care      (care),
		.hits      (hits)
	);

endmodule

// File: rtl/keyword_blacklist_matcher.sv
// keyword_blacklist_matcher: streaming keyword matcher over a row of
// history cells. Depends on kbm_pkg, kbm_cell, kbm_char_cmp.
//
//   channel | signals                                   | dir
//   input   | in_valid, in_ready, text_byte, last_byte  | in
//   output  | out_valid, out_ready, keyword_found       | out
//
// One byte is taken per cycle; all keyword compares finish in that cycle.
// A final byte leaves its result in the output register the next cycle.
// Non-final bytes are taken even while a result waits; a final byte waits
// only when the output register is full and out_ready is low.
// Reset clears the cell valid bits, the hit flag and the output valid bit.
module keyword_blacklist_matcher import kbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  char_t text_byte,
	input  logic  last_byte,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  keyword_found
);

	kbm_tap_t                    tap_w  [MAX_KEY_LEN];
	logic [KEY_COUNT-1:0]        hits_w [MAX_KEY_LEN];
	logic [KEY_COUNT-1:0][7:0]   exp_w  [MAX_KEY_LEN];
	logic [KEY_COUNT-1:0]        care_w [MAX_KEY_LEN];
	logic [KEY_COUNT-1:0]        key_all;
	kbm_ctrl_t                   ctrl;
	logic                        accept;
	logic                        match;
	logic                        hit_q;
	logic                        out_valid_q;
	logic                        found_q;

	assign in_ready   = !last_byte || !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign ctrl.shift = accept && !last_byte;
	assign ctrl.clear = accept && last_byte;

	assign tap_w[0].ch    = fold_char(text_byte);
	assign tap_w[0].valid = 1'b1;

	for (genvar j = 0; j < MAX_KEY_LEN; j++) begin : g_pos
		for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
			assign exp_w[j][k]  = key_char(k, j);
			assign care_w[j][k] = key_care(k, j);
		end
	end

	kbm_char_cmp u_head (
		.tap       (tap_w[0]),
		.exp_chars (exp_w[0]),
		.care      (care_w[0]),
		.hits      (hits_w[0])
	);

	for (genvar i = 0; i < HIST_LEN; i++) begin : g_cell
		kbm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.tap_in    (tap_w[i]),
			.exp_chars (exp_w[i+1]),
			.care      (care_w[i+1]),
			.tap_out   (tap_w[i+1]),
			.hits      (hits_w[i+1])
		);
	end

	always_comb begin
		key_all = key_nonempty();
		for (int j = 0; j < MAX_KEY_LEN; j++) begin
			key_all = key_all & hits_w[j];
		end
	end

	assign match = |key_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (ctrl.shift && match) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			found_q <= hit_q || match;
		end
	end

	assign out_valid     = out_valid_q;
	assign keyword_found = found_q;

endmodule

// File: rtl/kbm_checker.sv
// kbm_checker: port-level checks for keyword_blacklist_matcher, with the
// bind that attaches it. Depends on the top level's ports only.
module kbm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic last_byte,
	input logic out_valid,
	input logic out_ready,
	input logic keyword_found
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(keyword_found))
		else $error("result changed while stalled");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> out_valid)
		else $error("final item gave no result");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && last_byte) && !out_valid |=> !out_valid)
		else $error("result without final item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && last_byte |-> !in_ready)
		else $error("final item taken over a waiting result");

endmodule

bind keyword_blacklist_matcher kbm_checker u_kbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.last_byte     (last_byte),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.keyword_found (keyword_found)
);
